// File: hw/rtl/plp_pkg.sv
// Shared constants for the point-to-line projection block.
// No dependencies; used by the top level and the testbench.
package plp_pkg;

	// Width and reset value of the distance tolerance register.
	localparam int TOL_WIDTH = 31;
	localparam logic [TOL_WIDTH-1:0] TOL_RESET = 31'd66;

	// Number of register stages in the split multiplier.
	localparam int MUL_LATENCY = 3;

endpackage

// File: hw/rtl/plp_if.sv
// Valid/ready channel interfaces for query requests and result requests.
// Standalone; widths follow the coordinate width of the top level.
interface plp_query_if #(parameter int COORD_WIDTH = 32) ();
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] line_a_x;
	logic signed [COORD_WIDTH-1:0] line_a_y;
	logic signed [COORD_WIDTH-1:0] line_a_z;
	logic signed [COORD_WIDTH-1:0] line_b_x;
	logic signed [COORD_WIDTH-1:0] line_b_y;
	logic signed [COORD_WIDTH-1:0] line_b_z;
	logic signed [COORD_WIDTH-1:0] probe_x;
	logic signed [COORD_WIDTH-1:0] probe_y;
	logic signed [COORD_WIDTH-1:0] probe_z;

	modport source (output valid, line_a_x, line_a_y, line_a_z, line_b_x, line_b_y,
		line_b_z, probe_x, probe_y, probe_z, input ready);
	modport sink (input valid, line_a_x, line_a_y, line_a_z, line_b_x, line_b_y,
		line_b_z, probe_x, probe_y, probe_z, output ready);
endinterface

interface plp_result_if #(parameter int COORD_WIDTH = 32) ();
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] foot_x;
	logic signed [COORD_WIDTH-1:0] foot_y;
	logic signed [COORD_WIDTH-1:0] foot_z;
	logic already_on_line;
	logic degenerate_line;
	logic saturated;

	modport source (output valid, foot_x, foot_y, foot_z, already_on_line,
		degenerate_line, saturated, input ready);
	modport sink (input valid, foot_x, foot_y, foot_z, already_on_line,
		degenerate_line, saturated, output ready);
endinterface

// File: hw/rtl/plp_mul.sv
// Pipelined signed multiplier built from four half-width partial products.
// Standalone, its stage count matching MUL_LATENCY in plp_pkg; stalls with the shared enable.
module plp_mul #(
	parameter int AW = 33,
	parameter int BW = 33
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [AW-1:0]     a,
	input  logic signed [BW-1:0]     b,
	output logic signed [AW+BW-1:0]  p
);

	localparam int ALW = AW / 2;
	localparam int AHW = AW - ALW;
	localparam int BLW = BW / 2;
	localparam int BHW = BW - BLW;
	localparam int PW  = AW + BW;

	logic [AW-1:0] ma_s1;
	logic [BW-1:0] mb_s1;
	logic          neg_s1;
	logic [ALW+BLW-1:0] pll_s2;
	logic [ALW+BHW-1:0] plh_s2;
	logic [AHW+BLW-1:0] phl_s2;
	logic [AHW+BHW-1:0] phh_s2;
	logic               neg_s2;
	logic [PW-1:0]      sum_c;
	logic signed [PW-1:0] out_s3;

	// Recombine the partial products.
	always_comb begin
		sum_c = PW'(pll_s2) + (PW'(plh_s2) << BLW) + (PW'(phl_s2) << ALW)
			+ (PW'(phh_s2) << (ALW + BLW));
	end

	// Magnitudes, then partial products, then signed sum.
	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1  <= a[AW-1] ? (~a) + AW'(1) : a;
			mb_s1  <= b[BW-1] ? (~b) + BW'(1) : b;
			neg_s1 <= a[AW-1] ^ b[BW-1];
			pll_s2 <= ma_s1[ALW-1:0] * mb_s1[BLW-1:0];
			plh_s2 <= ma_s1[ALW-1:0] * mb_s1[BW-1:BLW];
			phl_s2 <= ma_s1[AW-1:ALW] * mb_s1[BLW-1:0];
			phh_s2 <= ma_s1[AW-1:ALW] * mb_s1[BW-1:BLW];
			neg_s2 <= neg_s1;
			out_s3 <= neg_s2 ? (~sum_c) + PW'(1) : sum_c;
		end
	end

	assign p = out_s3;

endmodule

// File: hw/rtl/plp_div.sv
// Pipelined restoring divider, one quotient bit per stage, rounded to nearest.
// Standalone; stalls with the shared enable. The quotient must fit QW bits.
module plp_div #(
	parameter int DENW = 66,
	parameter int QW   = 34
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [DENW+QW-1:0]   num,
	input  logic [DENW-1:0]      den,
	output logic [QW:0]          quot
);

	localparam int RW = DENW + QW;

	logic [RW-1:0]   rem_s [QW];
	logic [DENW-1:0] den_s [QW];
	logic [QW-1:0]   quo_s [QW];
	logic [QW:0]     quot_s;
	logic            rnd_c;

	wire [RW-1:0]   rin [QW];
	wire [DENW-1:0] din [QW];
	wire [QW-1:0]   qin [QW];
	wire [RW-1:0]   rnx [QW];
	wire [QW-1:0]   qnx [QW];

	// One trial subtraction per stage, most significant quotient bit first.
	for (genvar g = 0; g < QW; g++) begin : g_stage
		wire [RW-1:0] shifted;
		wire          fits;
		if (g == 0) begin : g_first
			assign rin[g] = num;
			assign din[g] = den;
			assign qin[g] = '0;
		end else begin : g_next
			assign rin[g] = rem_s[g-1];
			assign din[g] = den_s[g-1];
			assign qin[g] = quo_s[g-1];
		end
		assign shifted = RW'(din[g]) << (QW - 1 - g);
		assign fits    = rin[g] >= shifted;
		assign rnx[g]  = fits ? rin[g] - shifted : rin[g];
		assign qnx[g]  = fits ? qin[g] | (QW'(1) << (QW - 1 - g)) : qin[g];
	end

	// Round half up on the final remainder.
	assign rnd_c = {rem_s[QW-1][DENW-1:0], 1'b0} >= {1'b0, den_s[QW-1]};

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < QW; j++) begin
				rem_s[j] <= rnx[j];
				den_s[j] <= din[j];
				quo_s[j] <= qnx[j];
			end
			quot_s <= (QW+1)'(quo_s[QW-1]) + (QW+1)'(rnd_c);
		end
	end

	assign quot = quot_s;

endmodule

// File: hw/rtl/point_line_projection_3d.sv
// Foot of the perpendicular from a probe point onto a 3D line, exact fixed point.
// Pipelined; one request per cycle while the result side is not stalled.
// The depth comes from the two multiplier rounds and the one-bit-per-stage divider.
// A stall on the result side holds the whole pipeline; nothing is dropped or repeated.
// Reset clears all valid bits and loads the distance tolerance with 66.
// Depends on plp_pkg, plp_if, plp_mul and plp_div.
module point_line_projection_3d #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [plp_pkg::TOL_WIDTH-1:0]   cfg_wdata,
	plp_query_if.sink                       query,
	plp_result_if.source                    result
);

	localparam int W   = COORD_WIDTH;
	localparam int DW  = W + 1;
	localparam int NW  = 2 * DW + 1;
	localparam int DDW = 2 * DW;
	localparam int TW  = plp_pkg::TOL_WIDTH;
	localparam int TQW = 2 * TW;
	localparam int MW  = DW + NW + 1;
	localparam int NNW = 2 * NW;
	localparam int RHW = TQW + DDW;
	localparam int QW  = W + 2;
	localparam int FW  = QW + 3;
	localparam int LM  = plp_pkg::MUL_LATENCY;
	localparam int S2  = 1 + LM + 1;
	localparam int SM  = S2 + LM + 1;
	localparam int SD  = SM + 1;
	localparam int PL  = SD + QW + 1;
	localparam int SF  = PL + 1;

	logic                  en;
	logic [TW-1:0]         tol_q;
	logic [SF:1]           vld_s;

	logic signed [DW-1:0]  u_s1 [3];
	logic signed [DW-1:0]  v_s1 [3];
	logic signed [DW-1:0]  d_pipe_s [1:S2][3];
	logic signed [W-1:0]   p_pipe_s [1:PL][3];
	logic                  degen_pipe_s [1:PL];
	logic signed [NW-1:0]  n_s5 [3];
	logic [DDW-1:0]        dd_pipe_s [S2:SD];
	logic [TQW-1:0]        tol2_s5;
	logic [NNW-1:0]        nn_s9;
	logic [RHW-1:0]        rhs_s9;
	logic signed [MW-1:0]  m_s9 [3];
	logic [MW-2:0]         mabs_s10 [3];
	logic                  onl_pipe_s [SD:PL];
	logic                  mneg_pipe_s [SD:PL][3];

	wire signed [2*DW-1:0]     uv_a [3];
	wire signed [2*DW-1:0]     uv_b [3];
	wire signed [2*DW-1:0]     dsq [3];
	wire signed [2*TW+1:0]     tol2_w;
	wire signed [2*NW-1:0]     nsq [3];
	wire signed [TQW+DDW+1:0]  rhs_w;
	wire signed [DW+NW-1:0]    dn_a [3];
	wire signed [DW+NW-1:0]    dn_b [3];
	wire [QW:0]                quot [3];

	logic signed [FW-1:0]  off_c [3];
	logic signed [FW-1:0]  sum_c [3];
	logic signed [W-1:0]   foot_c [3];
	logic [2:0]            clip_c;

	logic signed [W-1:0]   foot_q [3];
	logic                  onl_q;
	logic                  degen_q;
	logic                  sat_q;

	// The pipeline advances unless a finished result is waiting.
	assign en          = !vld_s[SF] || result.ready;
	assign query.ready = en;

	// Configuration register and valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= plp_pkg::TOL_RESET;
			vld_s <= '0;
		end else begin
			if (cfg_we) begin
				tol_q <= cfg_wdata;
			end
			if (en) begin
				vld_s <= {vld_s[SF-1:1], query.valid};
			end
		end
	end

	// First multiplier round: cross product terms, squared direction, squared tolerance.
	for (genvar k = 0; k < 3; k++) begin : g_round1
		plp_mul #(.AW(DW), .BW(DW)) u_uv_a (.clk(clk), .en(en),
			.a(u_s1[(k+1)%3]), .b(v_s1[(k+2)%3]), .p(uv_a[k]));
		plp_mul #(.AW(DW), .BW(DW)) u_uv_b (.clk(clk), .en(en),
			.a(u_s1[(k+2)%3]), .b(v_s1[(k+1)%3]), .p(uv_b[k]));
		plp_mul #(.AW(DW), .BW(DW)) u_dsq (.clk(clk), .en(en),
			.a(d_pipe_s[1][k]), .b(d_pipe_s[1][k]), .p(dsq[k]));
	end

	plp_mul #(.AW(TW+1), .BW(TW+1)) u_tol2 (.clk(clk), .en(en),
		.a({1'b0, tol_q}), .b({1'b0, tol_q}), .p(tol2_w));

	// Second multiplier round: squared normal, tolerance bound, and d x n terms.
	for (genvar k = 0; k < 3; k++) begin : g_round2
		plp_mul #(.AW(NW), .BW(NW)) u_nsq (.clk(clk), .en(en),
			.a(n_s5[k]), .b(n_s5[k]), .p(nsq[k]));
		plp_mul #(.AW(DW), .BW(NW)) u_dn_a (.clk(clk), .en(en),
			.a(d_pipe_s[S2][(k+1)%3]), .b(n_s5[(k+2)%3]), .p(dn_a[k]));
		plp_mul #(.AW(DW), .BW(NW)) u_dn_b (.clk(clk), .en(en),
			.a(d_pipe_s[S2][(k+2)%3]), .b(n_s5[(k+1)%3]), .p(dn_b[k]));
		plp_div #(.DENW(DDW), .QW(QW)) u_div (.clk(clk), .en(en),
			.num(mabs_s10[k]), .den(dd_pipe_s[SD]), .quot(quot[k]));
	end

	plp_mul #(.AW(TQW+1), .BW(DDW+1)) u_rhs (.clk(clk), .en(en),
		.a({1'b0, tol2_s5}), .b({1'b0, dd_pipe_s[S2]}), .p(rhs_w));

	// Apply the signed offset to the probe and clamp to the coordinate range.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			off_c[k]  = mneg_pipe_s[PL][k] ? -$signed(FW'(quot[k])) : $signed(FW'(quot[k]));
			sum_c[k]  = FW'(p_pipe_s[PL][k]) + off_c[k];
			clip_c[k] = !((&sum_c[k][FW-1:W-1]) || !(|sum_c[k][FW-1:W-1]));
			if (!clip_c[k]) begin
				foot_c[k] = sum_c[k][W-1:0];
			end else if (sum_c[k][FW-1]) begin
				foot_c[k] = {1'b1, {(W-1){1'b0}}};
			end else begin
				foot_c[k] = {1'b0, {(W-1){1'b1}}};
			end
		end
	end

	// Datapath stages.
	always_ff @(posedge clk) begin
		if (en) begin
			// Differences and the degenerate check.
			u_s1[0] <= DW'(query.line_a_x) - DW'(query.probe_x);
			u_s1[1] <= DW'(query.line_a_y) - DW'(query.probe_y);
			u_s1[2] <= DW'(query.line_a_z) - DW'(query.probe_z);
			v_s1[0] <= DW'(query.line_b_x) - DW'(query.probe_x);
			v_s1[1] <= DW'(query.line_b_y) - DW'(query.probe_y);
			v_s1[2] <= DW'(query.line_b_z) - DW'(query.probe_z);
			d_pipe_s[1][0] <= DW'(query.line_b_x) - DW'(query.line_a_x);
			d_pipe_s[1][1] <= DW'(query.line_b_y) - DW'(query.line_a_y);
			d_pipe_s[1][2] <= DW'(query.line_b_z) - DW'(query.line_a_z);
			p_pipe_s[1][0] <= query.probe_x;
			p_pipe_s[1][1] <= query.probe_y;
			p_pipe_s[1][2] <= query.probe_z;
			degen_pipe_s[1] <= (query.line_a_x == query.line_b_x)
				&& (query.line_a_y == query.line_b_y) && (query.line_a_z == query.line_b_z);

			// Delay lines that carry operands alongside the arithmetic.
			for (int s = 2; s <= S2; s++) begin
				d_pipe_s[s] <= d_pipe_s[s-1];
			end
			for (int s = 2; s <= PL; s++) begin
				p_pipe_s[s]     <= p_pipe_s[s-1];
				degen_pipe_s[s] <= degen_pipe_s[s-1];
			end
			for (int s = S2 + 1; s <= SD; s++) begin
				dd_pipe_s[s] <= dd_pipe_s[s-1];
			end
			for (int s = SD + 1; s <= PL; s++) begin
				onl_pipe_s[s]  <= onl_pipe_s[s-1];
				mneg_pipe_s[s] <= mneg_pipe_s[s-1];
			end

			// Normal vector n = u x v and |d|^2.
			for (int k = 0; k < 3; k++) begin
				n_s5[k] <= NW'(uv_a[k]) - NW'(uv_b[k]);
			end
			dd_pipe_s[S2] <= $unsigned(dsq[0]) + $unsigned(dsq[1]) + $unsigned(dsq[2]);
			tol2_s5 <= tol2_w[TQW-1:0];

			// |n|^2, the tolerance bound and m = d x n.
			nn_s9  <= NNW'($unsigned(nsq[0])) + NNW'($unsigned(nsq[1]))
				+ NNW'($unsigned(nsq[2]));
			rhs_s9 <= rhs_w[RHW-1:0];
			for (int k = 0; k < 3; k++) begin
				m_s9[k] <= MW'(dn_a[k]) - MW'(dn_b[k]);
			end

			// Tolerance test and divider operands.
			onl_pipe_s[SD] <= nn_s9 < rhs_s9;
			for (int k = 0; k < 3; k++) begin
				mneg_pipe_s[SD][k] <= m_s9[k][MW-1];
				mabs_s10[k] <= m_s9[k][MW-1] ? (MW-1)'(-m_s9[k]) : (MW-1)'(m_s9[k]);
			end

			// Output register.
			for (int k = 0; k < 3; k++) begin
				foot_q[k] <= (degen_pipe_s[PL] || onl_pipe_s[PL]) ? p_pipe_s[PL][k] : foot_c[k];
			end
			degen_q <= degen_pipe_s[PL];
			onl_q   <= !degen_pipe_s[PL] && onl_pipe_s[PL];
			sat_q   <= !degen_pipe_s[PL] && !onl_pipe_s[PL] && (|clip_c);
		end
	end

	assign result.valid           = vld_s[SF];
	assign result.foot_x          = foot_q[0];
	assign result.foot_y          = foot_q[1];
	assign result.foot_z          = foot_q[2];
	assign result.already_on_line = onl_q;
	assign result.degenerate_line = degen_q;
	assign result.saturated       = sat_q;

	// The two pass-through cases exclude each other.
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.already_on_line && result.degenerate_line))
		else $error("on-line and degenerate flags both set");

	// Clipping only happens on a computed foot.
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.saturated |-> !result.already_on_line && !result.degenerate_line)
		else $error("saturation flagged on a pass-through result");

	// A held result freezes the intake.
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |-> !query.ready)
		else $error("request taken while the result is stalled");

	// A zero tolerance never reports the probe as on the line.
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (tol_q == '0) |-> !result.already_on_line)
		else $error("on-line flag with zero tolerance");

endmodule

// File: bench/plp_tb_pkg.sv
// Request types shared by the projection testbench top and its checker.
// Depends on nothing; coordinate width matches the default block width.
package plp_tb_pkg;

	localparam int CW = 32;

	typedef struct packed {
		logic signed [CW-1:0] line_a_x;
		logic signed [CW-1:0] line_a_y;
		logic signed [CW-1:0] line_a_z;
		logic signed [CW-1:0] line_b_x;
		logic signed [CW-1:0] line_b_y;
		logic signed [CW-1:0] line_b_z;
		logic signed [CW-1:0] probe_x;
		logic signed [CW-1:0] probe_y;
		logic signed [CW-1:0] probe_z;
	} query_t;

	typedef struct packed {
		logic signed [CW-1:0] foot_x;
		logic signed [CW-1:0] foot_y;
		logic signed [CW-1:0] foot_z;
		logic                 already_on_line;
		logic                 degenerate_line;
		logic                 saturated;
	} foot_t;

endpackage

// File: bench/plp_checker.sv
// Checker for the projection block: computes the expected foot of each accepted
// query and compares it with the result requests. Depends on plp_pkg,
// plp_tb_pkg and the channel interfaces in plp_if.
module plp_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [plp_pkg::TOL_WIDTH-1:0] cfg_wdata,
	plp_query_if                          query,
	plp_result_if                         result,
	output int                            fail_count,
	output int                            pending,
	output int                            n_checked,
	output int                            n_online,
	output int                            n_degen,
	output int                            n_sat
);
	timeunit 1ns;
	timeprecision 1ps;
	import plp_tb_pkg::*;

	typedef logic signed [255:0] wide_t;

	localparam wide_t COORD_MAX = (wide_t'(1) <<< (CW - 1)) - 1;
	localparam wide_t COORD_MIN = -(wide_t'(1) <<< (CW - 1));
	localparam wide_t OFFSET_CAP = wide_t'(1) <<< 62;

	logic [plp_pkg::TOL_WIDTH-1:0] tolerance;
	foot_t expected_feet[$];

	// Exact foot of the perpendicular, with rounding, tolerance and clamping.
	function automatic foot_t project_foot(query_t q, logic [plp_pkg::TOL_WIDTH-1:0] tol);
		wide_t a[3], b[3], p[3], u[3], v[3], d[3], n[3], m[3];
		wide_t dd, nn, tw, mag, quo, rem, f;
		foot_t r;
		a[0] = q.line_a_x; a[1] = q.line_a_y; a[2] = q.line_a_z;
		b[0] = q.line_b_x; b[1] = q.line_b_y; b[2] = q.line_b_z;
		p[0] = q.probe_x;  p[1] = q.probe_y;  p[2] = q.probe_z;
		for (int i = 0; i < 3; i++) begin
			u[i] = a[i] - p[i];
			v[i] = b[i] - p[i];
			d[i] = b[i] - a[i];
		end
		r.foot_x = q.probe_x;
		r.foot_y = q.probe_y;
		r.foot_z = q.probe_z;
		r.already_on_line = 1'b0;
		r.saturated = 1'b0;
		dd = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
		r.degenerate_line = (dd == 0);
		if (dd != 0) begin
			n[0] = u[1] * v[2] - u[2] * v[1];
			n[1] = u[2] * v[0] - u[0] * v[2];
			n[2] = u[0] * v[1] - u[1] * v[0];
			nn = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
			tw = wide_t'({1'b0, tol});
			if (nn < tw * tw * dd) begin
				r.already_on_line = 1'b1;
			end else begin
				m[0] = d[1] * n[2] - d[2] * n[1];
				m[1] = d[2] * n[0] - d[0] * n[2];
				m[2] = d[0] * n[1] - d[1] * n[0];
				for (int i = 0; i < 3; i++) begin
					// Round half away from zero on the magnitude.
					mag = (m[i] < 0) ? -m[i] : m[i];
					quo = mag / dd;
					rem = mag - quo * dd;
					if (2 * rem >= dd) quo = quo + 1;
					if (quo >= OFFSET_CAP) quo = OFFSET_CAP;
					f = p[i] + ((m[i] < 0) ? -quo : quo);
					if (f > COORD_MAX) begin
						f = COORD_MAX;
						r.saturated = 1'b1;
					end
					if (f < COORD_MIN) begin
						f = COORD_MIN;
						r.saturated = 1'b1;
					end
					case (i)
						0: r.foot_x = f[CW-1:0];
						1: r.foot_y = f[CW-1:0];
						default: r.foot_z = f[CW-1:0];
					endcase
				end
			end
		end
		return r;
	endfunction

	// Track the tolerance register, queue predictions and compare results.
	always @(posedge clk or negedge arst_n) begin
		query_t q;
		foot_t exp_foot;
		if (!arst_n) begin
			tolerance <= plp_pkg::TOL_RESET;
			fail_count <= 0;
			pending <= 0;
			n_checked <= 0;
			n_online <= 0;
			n_degen <= 0;
			n_sat <= 0;
			expected_feet.delete();
		end else begin
			if (query.valid && query.ready) begin
				q.line_a_x = query.line_a_x; q.line_a_y = query.line_a_y;
				q.line_a_z = query.line_a_z; q.line_b_x = query.line_b_x;
				q.line_b_y = query.line_b_y; q.line_b_z = query.line_b_z;
				q.probe_x = query.probe_x;   q.probe_y = query.probe_y;
				q.probe_z = query.probe_z;
				expected_feet.push_back(project_foot(q, tolerance));
			end
			if (result.valid && result.ready) begin
				if (expected_feet.size() == 0) begin
					$error("result request with no query outstanding");
					fail_count <= fail_count + 1;
				end else begin
					exp_foot = expected_feet.pop_front();
					n_checked <= n_checked + 1;
					n_online <= n_online + exp_foot.already_on_line;
					n_degen <= n_degen + exp_foot.degenerate_line;
					n_sat <= n_sat + exp_foot.saturated;
					if (result.foot_x !== exp_foot.foot_x ||
						result.foot_y !== exp_foot.foot_y ||
						result.foot_z !== exp_foot.foot_z ||
						result.already_on_line !== exp_foot.already_on_line ||
						result.degenerate_line !== exp_foot.degenerate_line ||
						result.saturated !== exp_foot.saturated)
						fail_count <= fail_count + 1;
					if (result.foot_x !== exp_foot.foot_x)
						$error("foot_x expected %0d got %0d", exp_foot.foot_x, result.foot_x);
					if (result.foot_y !== exp_foot.foot_y)
						$error("foot_y expected %0d got %0d", exp_foot.foot_y, result.foot_y);
					if (result.foot_z !== exp_foot.foot_z)
						$error("foot_z expected %0d got %0d", exp_foot.foot_z, result.foot_z);
					if (result.already_on_line !== exp_foot.already_on_line)
						$error("already_on_line expected %0b got %0b",
							exp_foot.already_on_line, result.already_on_line);
					if (result.degenerate_line !== exp_foot.degenerate_line)
						$error("degenerate_line expected %0b got %0b",
							exp_foot.degenerate_line, result.degenerate_line);
					if (result.saturated !== exp_foot.saturated)
						$error("saturated expected %0b got %0b",
							exp_foot.saturated, result.saturated);
				end
			end
			// Number of predictions still waiting for their result.
			pending <= expected_feet.size();
			if (cfg_we) tolerance <= cfg_wdata;
		end
	end

endmodule

// File: bench/point_line_projection_3d_tb.sv
// Testbench top for point_line_projection_3d: drives queries, tolerance writes
// and result backpressure, and reports the verdict. Depends on plp_pkg,
// plp_tb_pkg, plp_if, plp_checker and the block itself.
module point_line_projection_3d_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import plp_tb_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 60;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 205;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [plp_pkg::TOL_WIDTH-1:0] cfg_wdata;
	int fail_count, pending, n_checked, n_online, n_degen, n_sat;
	int sender_idle_pct, receiver_stall_pct, quiet_cycles;

	plp_query_if #(.COORD_WIDTH(CW)) query();
	plp_result_if #(.COORD_WIDTH(CW)) result();

	point_line_projection_3d #(.COORD_WIDTH(CW)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.query(query),
		.result(result)
	);

	plp_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.query(query),
		.result(result),
		.fail_count(fail_count),
		.pending(pending),
		.n_checked(n_checked),
		.n_online(n_online),
		.n_degen(n_degen),
		.n_sat(n_sat)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Random backpressure on the result channel.
	initial result.ready = 1'b0;
	always @(posedge clk) begin
		result.ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// Watchdog on cycles with no request moving on either channel.
	always @(posedge clk) begin
		if ((query.valid && query.ready) || (result.valid && result.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic query_t make_query(int ax, int ay, int az, int bx, int by, int bz,
		int px, int py, int pz);
		query_t q;
		q.line_a_x = ax; q.line_a_y = ay; q.line_a_z = az;
		q.line_b_x = bx; q.line_b_y = by; q.line_b_z = bz;
		q.probe_x = px;  q.probe_y = py;  q.probe_z = pz;
		return q;
	endfunction

	// Value in [-2^s, 2^s].
	function automatic int scaled_coord(int s);
		return int'($urandom_range(0, 2 * (1 << s))) - (1 << s);
	endfunction

	function automatic int edge_coord();
		case ($urandom_range(5))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2: return 32'sh8000_0001;
			3: return 32'sh7FFF_FFFE;
			4: return 0;
			default: return int'($urandom);
		endcase
	endfunction

	// Random query from a mix of general, degenerate, near-line, tiny and edge cases.
	function automatic query_t random_query();
		int c[9];
		int s, t;
		longint dx, dy, dz;
		query_t q;
		case ($urandom_range(9))
			3: begin
				for (int i = 0; i < 9; i++) c[i] = int'($urandom);
				c[3] = c[0]; c[4] = c[1]; c[5] = c[2];
			end
			4, 5: begin
				s = $urandom_range(20, 2);
				for (int i = 0; i < 6; i++) c[i] = scaled_coord(s);
				t = int'($urandom_range(16)) - 8;
				dx = longint'(c[3]) - c[0];
				dy = longint'(c[4]) - c[1];
				dz = longint'(c[5]) - c[2];
				c[6] = int'(c[0] + ((dx * t) >>> 2) + int'($urandom_range(200)) - 100);
				c[7] = int'(c[1] + ((dy * t) >>> 2) + int'($urandom_range(200)) - 100);
				c[8] = int'(c[2] + ((dz * t) >>> 2) + int'($urandom_range(200)) - 100);
			end
			6: for (int i = 0; i < 9; i++) c[i] = int'($urandom_range(8)) - 4;
			7: for (int i = 0; i < 9; i++) c[i] = edge_coord();
			8, 9: begin
				s = $urandom_range(30, 4);
				for (int i = 0; i < 9; i++) c[i] = scaled_coord(s);
			end
			default: for (int i = 0; i < 9; i++) c[i] = int'($urandom);
		endcase
		q = make_query(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8]);
		return q;
	endfunction

	task automatic send_query(query_t q);
		while ($urandom_range(99) < sender_idle_pct) begin
			query.valid <= 1'b0;
			@(posedge clk);
		end
		query.line_a_x <= q.line_a_x; query.line_a_y <= q.line_a_y;
		query.line_a_z <= q.line_a_z; query.line_b_x <= q.line_b_x;
		query.line_b_y <= q.line_b_y; query.line_b_z <= q.line_b_z;
		query.probe_x <= q.probe_x;   query.probe_y <= q.probe_y;
		query.probe_z <= q.probe_z;
		query.valid <= 1'b1;
		@(posedge clk);
		while (!query.ready) @(posedge clk);
	endtask

	// Stop sending and let the pipeline empty out.
	task automatic drain_results();
		query.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_idle(idle_mode_t mode);
		sender_idle_pct = (mode == IDLE_SENDER) ? 58 : (mode == IDLE_BOTH) ? 38 : 0;
		receiver_stall_pct = (mode == IDLE_RECEIVER) ? 58 : (mode == IDLE_BOTH) ? 38 : 0;
	endtask

	// Reset, directed corner queries, then random phases over several tolerances.
	initial begin
		logic [plp_pkg::TOL_WIDTH-1:0] tol_list[PHASES];
		query_t directed[$];
		int mx, mn;
		mx = 32'sh7FFF_FFFF;
		mn = 32'sh8000_0000;
		tol_list = '{31'd66, 31'd0, 31'h7FFF_FFFF, 31'd1, 31'd65536,
			31'd5000, 31'd66, 31'd300};
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		query.valid = 1'b0;
		query.line_a_x = 0; query.line_a_y = 0; query.line_a_z = 0;
		query.line_b_x = 0; query.line_b_y = 0; query.line_b_z = 0;
		query.probe_x = 0;  query.probe_y = 0;  query.probe_z = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Degenerate lines, extreme coordinates, exact on-line and near-line probes.
		directed.push_back(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_query(mn, mn, mn, mn, mn, mn, mx, mx, mx));
		directed.push_back(make_query(mx, mx, mx, mx, mx, mx, mn, mn, mn));
		directed.push_back(make_query(mn, mn, mn, mx, mx, mx, 0, 0, 0));
		directed.push_back(make_query(mx, mn, mx, mn, mx, mn, mx, mx, mn));
		directed.push_back(make_query(mn, mn, mn, mx, mx, mx, mn, mx, mn));
		directed.push_back(make_query(mx, 0, 0, mx - 1, 1, 0, mx, mn, 0));
		directed.push_back(make_query(mn, 0, 0, mn + 1, 1, 0, mn, mx, 0));
		directed.push_back(make_query(0, 0, 0, 65536, 0, 0, 32768, 0, 0));
		directed.push_back(make_query(0, 0, 0, 65536, 0, 0, 32768, 65, 0));
		directed.push_back(make_query(0, 0, 0, 65536, 0, 0, 32768, 66, 0));
		directed.push_back(make_query(0, 0, 0, 65536, 0, 0, 32768, 0, 67));
		directed.push_back(make_query(0, 0, 0, 2, 0, 0, 1, 3, 0));
		directed.push_back(make_query(0, 0, 0, 1, 1, 0, 1, 0, 0));
		directed.push_back(make_query(0, 0, 0, 2, 2, 0, 3, 0, 0));
		directed.push_back(make_query(-1, -1, -1, 1, 1, 1, 5, -3, 7));
		directed.push_back(make_query(100, 200, 300, 100, 200, 301, 0, 0, 0));
		directed.push_back(make_query(mn, 0, 0, mx, 0, 0, 0, mx, mn));
		directed.push_back(make_query(0, mn, 0, 0, mx, 0, mn, 0, mx));
		directed.push_back(make_query(-1, -1, -1, -1, -1, -1, -1, -1, -1));
		set_idle(IDLE_NONE);
		foreach (directed[i]) send_query(directed[i]);
		drain_results();

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph != 0) begin
				cfg_we <= 1'b1;
				cfg_wdata <= (ph == 5) ? 31'($urandom) : tol_list[ph];
				@(posedge clk);
				cfg_we <= 1'b0;
			end
			set_idle(idle_mode_t'(ph % 4));
			for (int k = 0; k < PHASE_ITEMS; k++) send_query(random_query());
			drain_results();
		end

		$display("Checked %0d projections across %0d tolerance settings and four handshake mixes.",
			n_checked, PHASES);
		$display("Of those, %0d were on the line, %0d degenerate and %0d clipped.",
			n_online, n_degen, n_sat);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// File: files.f
hw/rtl/plp_pkg.sv
hw/rtl/plp_if.sv
hw/rtl/plp_mul.sv
hw/rtl/plp_div.sv
hw/rtl/point_line_projection_3d.sv
bench/plp_tb_pkg.sv
bench/plp_checker.sv
bench/point_line_projection_3d_tb.sv
